// ----- hdl/point_rotate_about_center_top_assert.svh -----
// assertion macros shared by the rotation block
`ifndef POINT_ROTATE_ABOUT_CENTER_TOP_ASSERT_SVH
`define POINT_ROTATE_ABOUT_CENTER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PRAC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PRAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/prac_pkg.sv -----
`default_nettype none
package prac_pkg;

    localparam int COORD_W = 32;
    localparam int DIFF_W  = 33;

    // register indexes
    localparam logic [2:0] REG_ANGLE_X = 3'd0;
    localparam logic [2:0] REG_ANGLE_Y = 3'd1;
    localparam logic [2:0] REG_ANGLE_Z = 3'd2;
    localparam logic [2:0] REG_PIVOT_X = 3'd3;
    localparam logic [2:0] REG_PIVOT_Y = 3'd4;
    localparam logic [2:0] REG_PIVOT_Z = 3'd5;

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        logic                      last_in;
    } t_point_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] rx;
        logic signed [COORD_W-1:0] ry;
        logic signed [COORD_W-1:0] rz;
        logic                      last_out;
    } t_point_out;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_pivot;

    // point with the pivot removed
    typedef struct packed {
        logic signed [DIFF_W-1:0] x;
        logic signed [DIFF_W-1:0] y;
        logic signed [DIFF_W-1:0] z;
        logic                     last;
    } t_diff;

endpackage
`default_nettype wire

// ----- hdl/prac_fifo.sv -----
`default_nettype none
module prac_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [W-1:0]     i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [W-1:0]          o_data,
    output logic                  o_empty,
    output logic [$clog2(DEPTH):0] o_count
);
    localparam int AW = $clog2(DEPTH);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;
    logic          w_wr;
    logic          w_rd;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= r_wp + AW'(1);
            if (w_rd) r_rp <= r_rp + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(w_wr) - (AW+1)'(w_rd);
        end
    end
endmodule
`default_nettype wire

// ----- hdl/prac_front.sv -----
`default_nettype none
module prac_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire prac_pkg::t_point_in i_pt,
    input  wire logic              i_busy,
    output logic                   o_full,
    input  wire prac_pkg::t_pivot  i_pivot,
    input  wire logic              i_mid_pop,
    output prac_pkg::t_diff        o_mid_data,
    output logic                   o_mid_empty
);
    prac_pkg::t_diff w_diff;
    logic            w_mid_full;
    logic [2:0]      w_cnt;

    // stall intake while the queue is full or sines are being rebuilt
    assign o_full = w_mid_full || i_busy;

    // move the pivot to the origin
    always_comb begin
        w_diff.x    = prac_pkg::DIFF_W'(i_pt.px) - prac_pkg::DIFF_W'(i_pivot.x);
        w_diff.y    = prac_pkg::DIFF_W'(i_pt.py) - prac_pkg::DIFF_W'(i_pivot.y);
        w_diff.z    = prac_pkg::DIFF_W'(i_pt.pz) - prac_pkg::DIFF_W'(i_pivot.z);
        w_diff.last = i_pt.last_in;
    end

    // queue towards the rotation pipeline
    prac_fifo #(.W($bits(prac_pkg::t_diff)), .DEPTH(4)) u_mid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && !o_full),
        .i_data  (w_diff),
        .o_full  (w_mid_full),
        .i_pop   (i_mid_pop),
        .o_data  (o_mid_data),
        .o_empty (o_mid_empty),
        .o_count (w_cnt)
    );

    logic w_unused;
    assign w_unused = ^w_cnt;
endmodule
`default_nettype wire

// ----- hdl/prac_trig.sv -----
`default_nettype none
module prac_trig #(
    parameter int TFB = 16,
    parameter int EPS = 0
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [2:0]        i_start,
    input  wire logic [2:0][15:0]  i_angles,
    output logic                   o_busy,
    output logic [5:0][TFB+1:0]    o_trig
);
`include "point_rotate_about_center_top_assert.svh"

    // ceil(2^(32+l) / d), exact quotient multiplier for 32-bit dividends
    function automatic logic [32:0] f_recip(input int d, input int l);
        logic [64:0] num;
        num = (65'd1 << (32 + l)) + 65'(d - 1);
        return 33'(num / 65'(d));
    endfunction

    localparam int TW = TFB + 2;
    localparam int SH = 30 - TFB;
    localparam logic [35:0] RND = 36'((64'd1 << SH) >> 1);
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic [63:0] ANG_K  = PI_Q60 / 64'd11520;
    localparam logic [63:0] HALF30 = 64'd1 << 29;
    localparam logic [15:0] FULL_TURN = 16'd23040;
    localparam logic [15:0] QUARTER   = 16'd5760;
    localparam logic [31:0] Q30_ONE   = 32'd1 << 30;
    localparam logic [TW-1:0] T_ONE   = TW'(1) << TFB;

    // reciprocals of the sine factors (2n)(2n+1)
    localparam logic [32:0] RS1 = f_recip(6, 3);
    localparam logic [32:0] RS2 = f_recip(20, 5);
    localparam logic [32:0] RS3 = f_recip(42, 6);
    localparam logic [32:0] RS4 = f_recip(72, 7);
    localparam logic [32:0] RS5 = f_recip(110, 7);
    localparam logic [32:0] RS6 = f_recip(156, 8);
    localparam logic [32:0] RS7 = f_recip(210, 8);
    localparam logic [32:0] RS8 = f_recip(272, 9);
    // reciprocals of the cosine factors (2n-1)(2n)
    localparam logic [32:0] RC1 = f_recip(2, 1);
    localparam logic [32:0] RC2 = f_recip(12, 4);
    localparam logic [32:0] RC3 = f_recip(30, 5);
    localparam logic [32:0] RC4 = f_recip(56, 6);
    localparam logic [32:0] RC5 = f_recip(90, 7);
    localparam logic [32:0] RC6 = f_recip(132, 8);
    localparam logic [32:0] RC7 = f_recip(182, 8);
    localparam logic [32:0] RC8 = f_recip(240, 8);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RED  = 3'd1;
    localparam logic [2:0] S_X    = 3'd2;
    localparam logic [2:0] S_X2   = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_ACC  = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0]         r_st;
    logic [2:0]         r_pend;
    logic [1:0]         r_axis;
    logic [15:0]        r_r;
    logic [1:0]         r_q;
    logic [30:0]        r_x;
    logic [31:0]        r_x2;
    logic [31:0]        r_ts;
    logic [31:0]        r_tc;
    logic signed [35:0] r_sum_s;
    logic signed [35:0] r_sum_c;
    logic [3:0]         r_n;
    logic               r_sel;
    logic [31:0]        r_dv;
    logic [TW-1:0]      r_trig [6];

    logic [2:0]         w_pend;
    logic [2:0]         w_take;
    logic [1:0]         w_pick;
    logic [15:0]        w_ang;
    logic [16:0]        w_mag;
    logic [63:0]        w_xp;
    logic [63:0]        w_x2p;
    logic [63:0]        w_tp;
    logic [32:0]        w_m;
    logic [5:0]         w_sh;
    logic [64:0]        w_qp;
    logic [TW-1:0]      w_s;
    logic [TW-1:0]      w_c;

    // clamp to [0, 1] and round to the stored fraction
    function automatic logic [TFB:0] f_scale(input logic signed [35:0] v);
        logic [35:0] c;
        if (v < 36'sd0) c = '0;
        else if (v > $signed(36'(Q30_ONE))) c = 36'(Q30_ONE);
        else c = v;
        return (TFB+1)'((c + RND) >> SH);
    endfunction

    // pending axis requests, lowest first, taken once the angle is stored
    assign w_pend = r_pend | i_start;
    always_comb begin
        if (r_pend[0]) w_pick = 2'd0;
        else if (r_pend[1]) w_pick = 2'd1;
        else w_pick = 2'd2;
    end
    assign w_take = ((r_st == S_IDLE) && (r_pend != 3'd0)) ? (3'd1 << w_pick) : 3'd0;
    assign w_ang = i_angles[w_pick];
    assign w_mag = w_ang[15] ? 17'(-$signed({w_ang[15], w_ang})) : {1'b0, w_ang};

    // radians, its square and the next series term
    assign w_xp  = 64'(r_r[12:0]) * ANG_K;
    assign w_x2p = 64'(r_x) * 64'(r_x);
    assign w_tp  = (r_sel ? 64'(r_tc) : 64'(r_ts)) * 64'(r_x2);

    // reciprocal and shift for the factorial factors of the current term
    always_comb begin
        unique case ({r_sel, r_n})
            5'd1:    begin w_m = RS1; w_sh = 6'd35; end
            5'd2:    begin w_m = RS2; w_sh = 6'd37; end
            5'd3:    begin w_m = RS3; w_sh = 6'd38; end
            5'd4:    begin w_m = RS4; w_sh = 6'd39; end
            5'd5:    begin w_m = RS5; w_sh = 6'd39; end
            5'd6:    begin w_m = RS6; w_sh = 6'd40; end
            5'd7:    begin w_m = RS7; w_sh = 6'd40; end
            5'd8:    begin w_m = RS8; w_sh = 6'd41; end
            5'd18:   begin w_m = RC2; w_sh = 6'd36; end
            5'd19:   begin w_m = RC3; w_sh = 6'd37; end
            5'd20:   begin w_m = RC4; w_sh = 6'd38; end
            5'd21:   begin w_m = RC5; w_sh = 6'd39; end
            5'd22:   begin w_m = RC6; w_sh = 6'd40; end
            5'd23:   begin w_m = RC7; w_sh = 6'd40; end
            5'd24:   begin w_m = RC8; w_sh = 6'd40; end
            default: begin w_m = RC1; w_sh = 6'd33; end
        endcase
    end

    // exact truncating quotient by multiplying with the reciprocal
    assign w_qp = 65'(r_dv) * 65'(w_m);

    assign w_s = TW'(f_scale(r_sum_s));
    assign w_c = TW'(f_scale(r_sum_c));

    assign o_busy = (r_st != S_IDLE) || (w_pend != 3'd0);
    always_comb begin
        for (int i = 0; i < 6; i++) o_trig[i] = r_trig[i];
    end

    // sine and cosine sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_pend <= '0;
            for (int i = 0; i < 6; i += 2) begin
                r_trig[i]   <= T_ONE;
                r_trig[i+1] <= '0;
            end
        end else begin
            r_pend <= (r_pend & ~w_take) | i_start;
            unique case (r_st)
                S_IDLE: begin
                    if (r_pend != 3'd0) begin
                        r_axis <= w_pick;
                        if (w_mag <= 17'(EPS)) begin
                            r_trig[{w_pick, 1'b0}] <= T_ONE;
                            r_trig[{w_pick, 1'b1}] <= '0;
                        end else begin
                            r_r  <= w_ang[15] ? w_ang + 16'd46080 : w_ang;
                            r_q  <= '0;
                            r_st <= S_RED;
                        end
                    end
                end
                S_RED: begin
                    if (r_r >= FULL_TURN) begin
                        r_r <= r_r - FULL_TURN;
                    end else if (r_r >= QUARTER) begin
                        r_r <= r_r - QUARTER;
                        r_q <= r_q + 2'd1;
                    end else begin
                        r_st <= S_X;
                    end
                end
                S_X: begin
                    r_x  <= 31'((w_xp + HALF30) >> 30);
                    r_st <= S_X2;
                end
                S_X2: begin
                    r_x2    <= 32'((w_x2p + HALF30) >> 30);
                    r_ts    <= 32'(r_x);
                    r_tc    <= Q30_ONE;
                    r_sum_s <= 36'(r_x);
                    r_sum_c <= 36'(Q30_ONE);
                    r_n     <= 4'd1;
                    r_sel   <= 1'b0;
                    r_st    <= S_MUL;
                end
                S_MUL: begin
                    r_dv <= 32'((w_tp + HALF30) >> 30);
                    r_st <= S_DIV;
                end
                S_DIV: begin
                    r_dv <= 32'(w_qp >> w_sh);
                    r_st <= S_ACC;
                end
                S_ACC: begin
                    if (r_sel) begin
                        r_tc    <= r_dv;
                        r_sum_c <= r_n[0] ? r_sum_c - 36'(r_dv) : r_sum_c + 36'(r_dv);
                        r_sel   <= 1'b0;
                        if (r_n == 4'd8) begin
                            r_st <= S_FIN;
                        end else begin
                            r_n  <= r_n + 4'd1;
                            r_st <= S_MUL;
                        end
                    end else begin
                        r_ts    <= r_dv;
                        r_sum_s <= r_n[0] ? r_sum_s - 36'(r_dv) : r_sum_s + 36'(r_dv);
                        r_sel   <= 1'b1;
                        r_st    <= S_MUL;
                    end
                end
                S_FIN: begin
                    // quadrant swap and signs
                    case (r_q)
                        2'd0: begin
                            r_trig[{r_axis, 1'b0}] <= w_c;
                            r_trig[{r_axis, 1'b1}] <= w_s;
                        end
                        2'd1: begin
                            r_trig[{r_axis, 1'b0}] <= -w_s;
                            r_trig[{r_axis, 1'b1}] <= w_c;
                        end
                        2'd2: begin
                            r_trig[{r_axis, 1'b0}] <= -w_c;
                            r_trig[{r_axis, 1'b1}] <= -w_s;
                        end
                        default: begin
                            r_trig[{r_axis, 1'b0}] <= w_s;
                            r_trig[{r_axis, 1'b1}] <= -w_c;
                        end
                    endcase
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // the quotient step always hands over to the accumulate step
    `PRAC_ASSERT_NEXT(a_div_done, r_st == S_DIV, r_st == S_ACC, "divider overrun")
endmodule
`default_nettype wire

// ----- hdl/prac_back.sv -----
`default_nettype none
module prac_back #(
    parameter int TFB = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire prac_pkg::t_diff      i_mid_data,
    input  wire logic                 i_mid_empty,
    output logic                      o_mid_pop,
    input  wire logic [5:0][TFB+1:0]  i_trig,
    input  wire prac_pkg::t_pivot     i_pivot,
    input  wire logic                 i_pop,
    output prac_pkg::t_point_out      o_res,
    output logic                      o_empty
);
`include "point_rotate_about_center_top_assert.svh"

    localparam int TW = TFB + 2;
    localparam int CW = 37;
    localparam int PW = CW + TW;
    localparam int OUT_DEPTH = 8;
    localparam logic signed [CW:0] SAT_HI = (CW+1)'(64'sd2147483647);
    localparam logic signed [CW:0] SAT_LO = (CW+1)'(-64'sd2147483648);

    logic [3:0] r_cred;
    logic       r_v1, r_v2, r_v3, r_v4;
    logic       r_l1, r_l2, r_l3;
    logic signed [CW-1:0] r1_x, r1_p0, r1_p1, r1_p2, r1_p3;
    logic signed [CW-1:0] r2_y, r2_q0, r2_q1, r2_q2, r2_q3;
    logic signed [CW-1:0] r3_z, r3_u0, r3_u1, r3_u2, r3_u3;
    prac_pkg::t_point_out r4_res;

    logic signed [CW-1:0] w_x0, w_y0, w_z0;
    logic signed [CW-1:0] w_y1, w_z1, w_x2, w_z2, w_x3, w_y3;
    logic                 w_out_full;
    logic [3:0]           w_out_cnt;
    logic                 w_issue;
    logic                 w_ret;

    // round(a * t / 2^TFB), ties away from zero
    function automatic logic signed [CW-1:0] f_tmul(input logic signed [CW-1:0] a,
                                                    input logic signed [TW-1:0] t);
        logic          neg;
        logic [CW-1:0] ma;
        logic [TW-1:0] mt;
        logic [PW-1:0] pr;
        logic [CW-1:0] r;
        neg = a[CW-1] ^ t[TW-1];
        ma  = a[CW-1] ? -a : a;
        mt  = t[TW-1] ? -t : t;
        pr  = PW'(ma) * PW'(mt) + (PW'(1) << (TFB - 1));
        r   = CW'(pr >> TFB);
        return neg ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [31:0] f_sat(input logic signed [CW:0] v);
        if (v > SAT_HI) return 32'sh7fffffff;
        if (v < SAT_LO) return 32'sh80000000;
        return 32'(v);
    endfunction

    // issue when the output queue has room for everything in flight
    assign w_issue   = !i_mid_empty && (r_cred != 4'd0);
    assign o_mid_pop = w_issue;
    assign w_ret     = i_pop && !o_empty;

    assign w_x0 = CW'(i_mid_data.x);
    assign w_y0 = CW'(i_mid_data.y);
    assign w_z0 = CW'(i_mid_data.z);
    assign w_y1 = r1_p0 - r1_p1;
    assign w_z1 = r1_p2 + r1_p3;
    assign w_x2 = r2_q0 + r2_q1;
    assign w_z2 = r2_q2 - r2_q3;
    assign w_x3 = r3_u0 - r3_u1;
    assign w_y3 = r3_u2 + r3_u3;

    // rotation stages: x axis, y axis, z axis, pivot and saturate
    always_ff @(posedge i_clk) begin
        r1_x  <= w_x0;
        r1_p0 <= f_tmul(w_y0, i_trig[0]);
        r1_p1 <= f_tmul(w_z0, i_trig[1]);
        r1_p2 <= f_tmul(w_z0, i_trig[0]);
        r1_p3 <= f_tmul(w_y0, i_trig[1]);
        r_l1  <= i_mid_data.last;

        r2_y  <= w_y1;
        r2_q0 <= f_tmul(r1_x, i_trig[2]);
        r2_q1 <= f_tmul(w_z1, i_trig[3]);
        r2_q2 <= f_tmul(w_z1, i_trig[2]);
        r2_q3 <= f_tmul(r1_x, i_trig[3]);
        r_l2  <= r_l1;

        r3_z  <= w_z2;
        r3_u0 <= f_tmul(w_x2, i_trig[4]);
        r3_u1 <= f_tmul(r2_y, i_trig[5]);
        r3_u2 <= f_tmul(r2_y, i_trig[4]);
        r3_u3 <= f_tmul(w_x2, i_trig[5]);
        r_l3  <= r_l2;

        r4_res.rx       <= f_sat((CW+1)'(w_x3) + (CW+1)'(i_pivot.x));
        r4_res.ry       <= f_sat((CW+1)'(w_y3) + (CW+1)'(i_pivot.y));
        r4_res.rz       <= f_sat((CW+1)'(r3_z) + (CW+1)'(i_pivot.z));
        r4_res.last_out <= r_l3;
    end

    // stage valids and output credits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_cred <= 4'(OUT_DEPTH);
        end else begin
            r_v1   <= w_issue;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_v4   <= r_v3;
            r_cred <= r_cred - 4'(w_issue) + 4'(w_ret);
        end
    end

    // result queue
    prac_fifo #(.W($bits(prac_pkg::t_point_out)), .DEPTH(OUT_DEPTH)) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_v4),
        .i_data  (r4_res),
        .o_full  (w_out_full),
        .i_pop   (i_pop),
        .o_data  (o_res),
        .o_empty (o_empty),
        .o_count (w_out_cnt)
    );

    // credits, items in flight and queued results always add up to the queue depth
    `PRAC_ASSERT_NOW(a_credit, 1'b1, 5'(r_cred) + 5'(r_v1) + 5'(r_v2) + 5'(r_v3) + 5'(r_v4) + 5'(w_out_cnt) == 5'(OUT_DEPTH), "credit leak")
    // a finished result always finds room
    `PRAC_ASSERT_NOW(a_no_drop, r_v4, !w_out_full, "result dropped")
    // nothing is issued without a credit
    `PRAC_ASSERT_NOW(a_issue, o_mid_pop, r_cred != 4'd0 && !i_mid_empty, "issue without credit")
endmodule
`default_nettype wire

// ----- hdl/point_rotate_about_center_top.sv -----
// path: accepted points pass the mid queue, rotation stages and result queue
// throughput: one point per cycle while not full (four-stage rotation pipeline)
// an angle write rebuilds its sine and cosine in a shared multiply sequencer:
//   full stays high while a rebuild is pending or running
// reset: synchronous, active low; control and config reset, cosines one, sines zero
`default_nettype none
module point_rotate_about_center_top #(
    parameter int TRIG_FRACTION_BITS = 16,
    parameter int ANGLE_EPSILON      = 0
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    push,
    input  wire prac_pkg::t_point_in     i_pt,
    output logic                         full,
    input  wire logic                    pop,
    output prac_pkg::t_point_out         o_res,
    output logic                         empty,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [4:0]              paddr,
    input  wire logic [31:0]             pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    localparam int TW = TRIG_FRACTION_BITS + 2;

    logic [2:0][15:0]        r_ang;
    prac_pkg::t_pivot        r_piv;
    logic [2:0]              w_start;
    logic                    w_wr;
    logic [2:0]              w_idx;
    logic                    w_busy;
    logic [5:0][TW-1:0]      w_trig;
    prac_pkg::t_diff         w_mid_data;
    logic                    w_mid_empty;
    logic                    w_mid_pop;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = paddr[4:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang <= '0;
            r_piv <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                prac_pkg::REG_ANGLE_X: r_ang[0] <= pwdata[15:0];
                prac_pkg::REG_ANGLE_Y: r_ang[1] <= pwdata[15:0];
                prac_pkg::REG_ANGLE_Z: r_ang[2] <= pwdata[15:0];
                prac_pkg::REG_PIVOT_X: r_piv.x  <= pwdata;
                prac_pkg::REG_PIVOT_Y: r_piv.y  <= pwdata;
                prac_pkg::REG_PIVOT_Z: r_piv.z  <= pwdata;
                default: ;
            endcase
        end
    end

    // angle writes kick off a sine/cosine rebuild
    always_comb begin
        w_start = '0;
        if (w_wr) begin
            unique case (w_idx)
                prac_pkg::REG_ANGLE_X: w_start[0] = 1'b1;
                prac_pkg::REG_ANGLE_Y: w_start[1] = 1'b1;
                prac_pkg::REG_ANGLE_Z: w_start[2] = 1'b1;
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (w_idx)
            prac_pkg::REG_ANGLE_X: prdata = 32'($signed(r_ang[0]));
            prac_pkg::REG_ANGLE_Y: prdata = 32'($signed(r_ang[1]));
            prac_pkg::REG_ANGLE_Z: prdata = 32'($signed(r_ang[2]));
            prac_pkg::REG_PIVOT_X: prdata = r_piv.x;
            prac_pkg::REG_PIVOT_Y: prdata = r_piv.y;
            prac_pkg::REG_PIVOT_Z: prdata = r_piv.z;
            default:               prdata = '0;
        endcase
    end

    prac_trig #(.TFB(TRIG_FRACTION_BITS), .EPS(ANGLE_EPSILON)) u_trig (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_angles (r_ang),
        .o_busy   (w_busy),
        .o_trig   (w_trig)
    );

    prac_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pt        (i_pt),
        .i_busy      (w_busy),
        .o_full      (full),
        .i_pivot     (r_piv),
        .i_mid_pop   (w_mid_pop),
        .o_mid_data  (w_mid_data),
        .o_mid_empty (w_mid_empty)
    );

    prac_back #(.TFB(TRIG_FRACTION_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_data  (w_mid_data),
        .i_mid_empty (w_mid_empty),
        .o_mid_pop   (w_mid_pop),
        .i_trig      (w_trig),
        .i_pivot     (r_piv),
        .i_pop       (pop),
        .o_res       (o_res),
        .o_empty     (empty)
    );
endmodule
`default_nettype wire
